### hw/rtl/vtpg_pkg.sv
package vtpg_pkg;

    // coordinate width used when the top level is not overridden
    localparam int COORD_BITS_DEF = 13;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PANE_HEIGHT = 2'd1;

    // pane size after reset
    localparam logic [15:0] PANE_WIDTH_RST  = 16'd640;
    localparam logic [15:0] PANE_HEIGHT_RST = 16'd480;

    // border thickness in pixels
    localparam int FRAME_PIX = 3;

    // tolerance multipliers of the pixel-center comparisons
    localparam int TOL_X_MUL = 125;
    localparam int TOL_Y_MUL = 250;

    typedef logic [31:0] t_argb;

    localparam t_argb COL_FRAME     = 32'hFF3090A8;
    localparam t_argb COL_CROSS     = 32'hFFC3DADC;
    localparam t_argb COL_QUARTER   = 32'hFF305764;
    localparam t_argb COL_CELL_ODD  = 32'hFF121C22;
    localparam t_argb COL_CELL_EVEN = 32'hFF0D151B;

endpackage

### hw/rtl/vtpg_pix_if.sv
interface vtpg_pix_if #(
    parameter int COORD_BITS = vtpg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### hw/rtl/vtpg_argb_if.sv
interface vtpg_argb_if;
    logic                  valid;
    logic                  ready;
    vtpg_pkg::t_argb       argb_color;

    modport source (output valid, output argb_color, input ready);
    modport sink   (input valid, input argb_color, output ready);
endinterface

### hw/rtl/video_test_pattern_generator_core.sv
// a pixel accepted at the input passes the stage 1 and stage 2 registers, then the output register
// throughput: one pixel per cycle unless the output stalls; three-stage pipeline, one quotient bit per stage
// a stalled output holds the whole pipe; bubbles are squeezed out while the output waits
// reset (synchronous, active low) empties every stage and sets the pane to 640 x 480
module video_test_pattern_generator_core #(
    parameter int COORD_BITS = vtpg_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vtpg_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]             i_cfg_data,
    vtpg_pix_if.sink                          i_pix,
    vtpg_argb_if.source                       o_argb
);
    import vtpg_pkg::*;

    localparam int CW = COORD_BITS;
    // wide enough for 250 * |4y + 2 - 3h|
    localparam int MW = COORD_BITS + 11;

    function automatic logic [MW-1:0] f_absdiff(input logic [MW-1:0] a, input logic [MW-1:0] b);
        logic [MW-1:0] r;
        r = (a > b) ? (a - b) : (b - a);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [CW-1:0] r_pane_w;
    logic [CW-1:0] r_pane_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pane_w <= CW'(PANE_WIDTH_RST);
            r_pane_h <= CW'(PANE_HEIGHT_RST);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_PANE_WIDTH) begin
                r_pane_w <= i_cfg_data;
            end else if (i_cfg_idx == CFG_PANE_HEIGHT) begin
                r_pane_h <= i_cfg_data;
            end
        end
    end

    // widened copies of the pane size for the tolerance compares
    logic [MW-1:0] w_ext;
    logic [MW-1:0] h_ext;
    logic [MW-1:0] w3_ext;
    logic [MW-1:0] h3_ext;

    assign w_ext  = MW'(r_pane_w);
    assign h_ext  = MW'(r_pane_h);
    assign w3_ext = w_ext + MW'({r_pane_w, 1'b0});
    assign h3_ext = h_ext + MW'({r_pane_h, 1'b0});

    // ---------------------------------------------------------------
    // stall chain: each stage moves when the one after it can take data
    // ---------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic rdy1, rdy2, rdy3;

    assign rdy3        = !r_v3 || o_argb.ready;
    assign rdy2        = !r_v2 || rdy3;
    assign rdy1        = !r_v1 || rdy2;
    assign i_pix.ready = rdy1;

    // ---------------------------------------------------------------
    // stage 1: border test, distances to center and quarter lines,
    // top quotient bit of 8x/w and 8y/h
    // ---------------------------------------------------------------
    logic [CW:0]   x_plus3;
    logic [CW:0]   y_plus3;
    logic          n_frame1;
    logic [MW-1:0] x2p1, x4p2, y2p1, y4p2;
    logic [CW:0]   tx0, ty0;
    logic          qx0, qy0;
    logic [CW-1:0] n_remx1, n_remy1;

    logic          r_frame1;
    logic [MW-1:0] r_dxc1, r_dxq1, r_dxt1;
    logic [MW-1:0] r_dyc1, r_dyq1, r_dyt1;
    logic [CW-1:0] r_remx1, r_remy1;

    always_comb begin
        x_plus3  = (CW+1)'(i_pix.pixel_x) + (CW+1)'(FRAME_PIX);
        y_plus3  = (CW+1)'(i_pix.pixel_y) + (CW+1)'(FRAME_PIX);
        // also covers a zero-size pane and coordinates outside the pane
        n_frame1 = (i_pix.pixel_x < CW'(FRAME_PIX)) || (i_pix.pixel_y < CW'(FRAME_PIX)) ||
                   (x_plus3 >= (CW+1)'(r_pane_w)) || (y_plus3 >= (CW+1)'(r_pane_h));

        x2p1 = MW'({i_pix.pixel_x, 1'b1});
        x4p2 = MW'({i_pix.pixel_x, 2'b10});
        y2p1 = MW'({i_pix.pixel_y, 1'b1});
        y4p2 = MW'({i_pix.pixel_y, 2'b10});

        // restoring division, first step: remainder starts at x (< w)
        tx0     = {i_pix.pixel_x, 1'b0};
        ty0     = {i_pix.pixel_y, 1'b0};
        qx0     = tx0 >= (CW+1)'(r_pane_w);
        qy0     = ty0 >= (CW+1)'(r_pane_h);
        n_remx1 = qx0 ? CW'(tx0 - (CW+1)'(r_pane_w)) : CW'(tx0);
        n_remy1 = qy0 ? CW'(ty0 - (CW+1)'(r_pane_h)) : CW'(ty0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_frame1 <= n_frame1;
            r_dxc1   <= f_absdiff(x2p1, w_ext);
            r_dxq1   <= f_absdiff(x4p2, w_ext);
            r_dxt1   <= f_absdiff(x4p2, w3_ext);
            r_dyc1   <= f_absdiff(y2p1, h_ext);
            r_dyq1   <= f_absdiff(y4p2, h_ext);
            r_dyt1   <= f_absdiff(y4p2, h3_ext);
            r_remx1  <= n_remx1;
            r_remy1  <= n_remy1;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: tolerance compares, middle quotient bit
    // ---------------------------------------------------------------
    logic          n_cross2, n_quart2;
    logic [CW:0]   tx1, ty1;
    logic          qx1, qy1;
    logic [CW-1:0] n_remx2, n_remy2;

    logic          r_frame2, r_cross2, r_quart2;
    logic [CW-1:0] r_remx2, r_remy2;

    always_comb begin
        // constant multiplies reduce to shift-and-add
        n_cross2 = (MW'(r_dxc1 * MW'(TOL_X_MUL)) < w_ext) ||
                   (MW'(r_dyc1 * MW'(TOL_Y_MUL)) < h3_ext);
        n_quart2 = (MW'(r_dxq1 * MW'(TOL_X_MUL)) < w_ext) ||
                   (MW'(r_dxt1 * MW'(TOL_X_MUL)) < w_ext) ||
                   (MW'(r_dyq1 * MW'(TOL_Y_MUL)) < h3_ext) ||
                   (MW'(r_dyt1 * MW'(TOL_Y_MUL)) < h3_ext);

        tx1     = {r_remx1, 1'b0};
        ty1     = {r_remy1, 1'b0};
        qx1     = tx1 >= (CW+1)'(r_pane_w);
        qy1     = ty1 >= (CW+1)'(r_pane_h);
        n_remx2 = qx1 ? CW'(tx1 - (CW+1)'(r_pane_w)) : CW'(tx1);
        n_remy2 = qy1 ? CW'(ty1 - (CW+1)'(r_pane_h)) : CW'(ty1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_frame2 <= r_frame1;
            r_cross2 <= n_cross2;
            r_quart2 <= n_quart2;
            r_remx2  <= n_remx2;
            r_remy2  <= n_remy2;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: last quotient bit, checkerboard parity, color pick
    // ---------------------------------------------------------------
    logic [CW:0] tx2, ty2;
    logic        qx2, qy2;
    t_argb       n_argb;
    t_argb       r_argb;

    always_comb begin
        tx2 = {r_remx2, 1'b0};
        ty2 = {r_remy2, 1'b0};
        qx2 = tx2 >= (CW+1)'(r_pane_w);
        qy2 = ty2 >= (CW+1)'(r_pane_h);

        // priority: border, crosshair, quarter lines, checkerboard
        if (r_frame2) begin
            n_argb = COL_FRAME;
        end else if (r_cross2) begin
            n_argb = COL_CROSS;
        end else if (r_quart2) begin
            n_argb = COL_QUARTER;
        end else if (qx2 ^ qy2) begin
            n_argb = COL_CELL_ODD;
        end else begin
            n_argb = COL_CELL_EVEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (rdy3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_argb <= n_argb;
        end
    end

    assign o_argb.valid      = r_v3;
    assign o_argb.argb_color = r_argb;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_accept_enters_stage1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v1)
        else $error("accepted pixel did not enter stage 1");

    a_remainder_below_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r_frame1) |-> (r_remx1 < r_pane_w) && (r_remy1 < r_pane_h))
        else $error("division remainder out of range inside the pane");

    a_frame_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_frame2 && rdy3) |=> (o_argb.argb_color == COL_FRAME))
        else $error("border pixel did not get the border color");

    a_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_argb.valid |-> (o_argb.argb_color[31:24] == 8'hFF))
        else $error("output color is not opaque");

endmodule
